// File: src/tle_pkg.sv
// shared types and constants for the console line editor with word wrap
// no dependencies; imported by every module of the block
package tle_pkg;

	// line geometry
	localparam int LINE_LEN = 32;
	localparam int LEN_W    = $clog2(LINE_LEN + 1);
	localparam int ADDR_W   = $clog2(LINE_LEN);
	localparam int BYTE_W   = 8;
	localparam int CHAR_W   = 7;

	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_LEN);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_LEN - 1);

	// character codes
	localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
	localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_LO   = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI   = 8'h7E;
	localparam logic [BYTE_W-1:0] NL_BYTE    = 8'h0A;

	// register reset values
	localparam logic [BYTE_W-1:0] ERASE_RST  = 8'd127;
	localparam logic [BYTE_W-1:0] KILL_RST   = 8'd21;
	localparam logic [BYTE_W-1:0] WERASE_RST = 8'd23;
	localparam logic [BYTE_W-1:0] EOF_RST    = 8'd4;

	// result kinds
	typedef enum logic [2:0] {
		KIND_ECHO    = 3'd0,
		KIND_RUB     = 3'd1,
		KIND_NEWLINE = 3'd2,
		KIND_BELL    = 3'd3,
		KIND_EOF     = 3'd4
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ERASE  = 2'd0,
		CFG_KILL   = 2'd1,
		CFG_WERASE = 2'd2,
		CFG_EOF    = 2'd3
	} cfg_idx_t;

	// what the sequencer is doing for the current item
	typedef enum logic [2:0] {
		OP_PRINT,
		OP_WRAP,
		OP_WERASE,
		OP_LINE,
		OP_RUB
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_RUB,
		S_NL,
		S_COPY_RD,
		S_COPY_WR,
		S_ECHO,
		S_ONE
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] erase_char;
		logic [BYTE_W-1:0] kill_char;
		logic [BYTE_W-1:0] word_erase_char;
		logic [BYTE_W-1:0] end_of_file_char;
	} cfg_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CHAR_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} emit_t;

	typedef struct packed {
		logic             busy;
		logic [LEN_W-1:0] len;
	} stat_t;

endpackage

// File: src/tle_line_mem.sv
// line buffer: one write port, one read port with registered read data
// depends on tle_pkg
module tle_line_mem
	import tle_pkg::*;
(
	input  logic              clk,
	input  mem_req_t          req,
	output logic [CHAR_W-1:0] rdata
);

	logic [CHAR_W-1:0] mem_q [LINE_LEN];
	logic [CHAR_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/tle_ctrl.sv
// sequencer: decodes an input byte, scans and rewrites the line one character
// at a time through a single decrement/compare path; depends on tle_pkg
module tle_ctrl
	import tle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              out_ready,
	input  logic [CHAR_W-1:0] rdata,
	output mem_req_t          mem_req,
	output emit_t             emit,
	output stat_t             stat
);

	state_t            state_q, state_d;
	op_t               op_q;
	kind_t             kind_q;
	logic              phase_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  p_q;
	logic [LEN_W-1:0]  j_q;
	logic [LEN_W-1:0]  rub_q;
	logic [CHAR_W-1:0] b_q;

	logic              len_zero, len_full, p_zero, rd_space, fire;
	logic [LEN_W-1:0]  p_dec;
	state_t            start_state;
	op_t               start_op;
	kind_t             start_kind;
	logic [LEN_W-1:0]  start_rub;

	assign len_zero = (len_q == '0);
	assign len_full = (len_q == LEN_FULL);
	assign p_zero   = (p_q == '0);
	assign p_dec    = p_q - LEN_W'(1);
	assign rd_space = (rdata == SPACE_CHAR);
	assign fire     = emit.valid && out_ready;

	// item decode, classes in priority order
	always_comb begin
		start_state = S_ONE;
		start_op    = OP_RUB;
		start_kind  = KIND_BELL;
		start_rub   = len_q;
		if (in_byte >= PRINT_LO && in_byte <= PRINT_HI) begin
			if (!len_full) begin
				start_state = S_ECHO;
				start_op    = OP_PRINT;
			end else if (in_byte == SPACE_BYTE) begin
				start_state = S_NL;
				start_op    = OP_PRINT;
			end else begin
				start_state = S_SCAN_RD;
				start_op    = OP_WRAP;
			end
		end else if (in_byte == cfg.erase_char && !len_zero) begin
			start_state = S_RUB;
			start_rub   = LEN_W'(1);
		end else if (in_byte == cfg.kill_char) begin
			start_state = len_zero ? S_IDLE : S_RUB;
		end else if (in_byte == cfg.word_erase_char) begin
			start_state = len_zero ? S_IDLE : S_SCAN_RD;
			start_op    = OP_WERASE;
		end else if (in_byte == cfg.end_of_file_char && len_zero) begin
			start_kind  = KIND_EOF;
		end else if (in_byte == NL_BYTE) begin
			start_state = S_NL;
			start_op    = OP_LINE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = start_state;
				end
			end
			S_SCAN_RD: begin
				if (p_zero) begin
					state_d = (op_q == OP_WRAP) ? S_NL : S_RUB;
				end else begin
					state_d = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (!phase_q) begin
					if (!rd_space) begin
						state_d = S_SCAN_RD;
					end else if (op_q == OP_WRAP) begin
						state_d = (len_q == p_q) ? S_NL : S_RUB;
					end else begin
						state_d = S_SCAN_RD;
					end
				end else begin
					state_d = rd_space ? S_SCAN_RD : S_RUB;
				end
			end
			S_RUB: begin
				if (fire && rub_q == LEN_W'(1)) begin
					state_d = (op_q == OP_WRAP) ? S_NL : S_IDLE;
				end
			end
			S_NL: begin
				if (fire) begin
					if (op_q == OP_LINE) begin
						state_d = S_IDLE;
					end else if (op_q == OP_WRAP && !p_zero && p_q != LEN_FULL) begin
						state_d = S_COPY_RD;
					end else begin
						state_d = S_ECHO;
					end
				end
			end
			S_COPY_RD: begin
				state_d = S_COPY_WR;
			end
			S_COPY_WR: begin
				if (fire) begin
					state_d = (p_q == LEN_LAST) ? S_ECHO : S_COPY_RD;
				end
			end
			S_ECHO, S_ONE: begin
				if (fire) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: result, memory requests, status
	always_comb begin
		emit          = '0;
		emit.kind     = KIND_ECHO;
		mem_req       = '0;
		mem_req.wdata = b_q;
		unique case (state_q)
			S_SCAN_RD: begin
				mem_req.re    = !p_zero;
				mem_req.raddr = p_dec[ADDR_W-1:0];
			end
			S_COPY_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = p_q[ADDR_W-1:0];
			end
			S_RUB: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_RUB;
				emit.last  = (rub_q == LEN_W'(1)) && (op_q != OP_WRAP);
			end
			S_NL: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_NEWLINE;
				emit.last  = (op_q == OP_LINE);
			end
			S_COPY_WR: begin
				emit.valid    = 1'b1;
				emit.ch       = rdata;
				mem_req.we    = fire;
				mem_req.waddr = j_q[ADDR_W-1:0];
				mem_req.wdata = rdata;
			end
			S_ECHO: begin
				emit.valid    = 1'b1;
				emit.ch       = b_q;
				emit.last     = 1'b1;
				mem_req.we    = fire;
				mem_req.waddr = len_q[ADDR_W-1:0];
			end
			S_ONE: begin
				emit.valid = 1'b1;
				emit.kind  = kind_q;
				emit.last  = 1'b1;
			end
			default: begin
			end
		endcase
		stat.busy = (state_q != S_IDLE);
		stat.len  = len_q;
	end

	// state and line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_RUB: begin
					if (fire) begin
						len_q <= len_q - LEN_W'(1);
					end
				end
				S_NL: begin
					if (fire) begin
						len_q <= '0;
					end
				end
				S_COPY_WR, S_ECHO: begin
					if (fire) begin
						len_q <= len_q + LEN_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					b_q     <= in_byte[CHAR_W-1:0];
					op_q    <= start_op;
					kind_q  <= start_kind;
					rub_q   <= start_rub;
					p_q     <= len_q;
					phase_q <= 1'b0;
				end
			end
			S_SCAN_RD: begin
				rub_q <= len_q - p_q;
			end
			S_SCAN_CMP: begin
				rub_q <= len_q - p_q;
				if (!phase_q) begin
					if (!rd_space) begin
						p_q <= p_dec;
					end else if (op_q == OP_WERASE) begin
						phase_q <= 1'b1;
						p_q     <= p_dec;
					end
				end else if (rd_space) begin
					p_q <= p_dec;
				end
			end
			S_RUB: begin
				if (fire) begin
					rub_q <= rub_q - LEN_W'(1);
				end
			end
			S_NL: begin
				j_q <= '0;
			end
			S_COPY_WR: begin
				if (fire) begin
					j_q <= j_q + LEN_W'(1);
					p_q <= p_q + LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/tty_line_editor_wordwrap.sv
// top level of the console line editor with word wrap
// depends on tle_pkg, tle_line_mem and tle_ctrl
//
// Usage:
//   input channel:  in_valid / in_stall / in_byte, one received byte per item
//   output channel: out_valid / out_stall / out_kind, out_char, last; each
//                   item is one terminal action, last marks the final action
//                   of an input byte (kill or word-erase on an empty line
//                   produce no action at all)
//   config port:    cfg_wr_en / cfg_index / cfg_wr_data, written while idle
// Timing:
//   the block takes one byte at a time; in_stall is high until every action
//   of the current byte has entered the output register. Each character
//   checked while scanning back for a space passes a read and a compare
//   state, and each moved character a read and a write state, both set by
//   the single read port of the line buffer. When out_stall is high while
//   a result is held, the output register holds and the sequencer waits
//   at its next result.
// Reset: line empty, registers at their defaults, no result pending.
module tty_line_editor_wordwrap
	import tle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        out_kind,
	output logic [CHAR_W-1:0] out_char,
	output logic              last,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_wr_data
);

	cfg_t              cfg_q;
	mem_req_t          mem_req;
	emit_t             emit;
	stat_t             stat;
	logic [CHAR_W-1:0] rdata;
	logic              out_ready;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.erase_char       <= ERASE_RST;
			cfg_q.kill_char        <= KILL_RST;
			cfg_q.word_erase_char  <= WERASE_RST;
			cfg_q.end_of_file_char <= EOF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ERASE:  cfg_q.erase_char       <= cfg_wr_data;
				CFG_KILL:   cfg_q.kill_char        <= cfg_wr_data;
				CFG_WERASE: cfg_q.word_erase_char  <= cfg_wr_data;
				CFG_EOF:    cfg_q.end_of_file_char <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	tle_line_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	tle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.out_ready (out_ready),
		.rdata     (rdata),
		.mem_req   (mem_req),
		.emit      (emit),
		.stat      (stat)
	);

	assign in_stall  = stat.busy;
	assign out_ready = !out_valid_q || !out_stall;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid && out_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && out_ready) begin
			kind_q <= emit.kind;
			char_q <= emit.ch;
			last_q <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_char  = char_q;
	assign last      = last_q;

	// line length never exceeds the buffer
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.len <= LEN_FULL)
		else $error("line length out of range");

	// the final result of a byte returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && out_ready && emit.last) |=> !stat.busy)
		else $error("sequencer busy after final result");

	// echoed characters are printable, other kinds carry no character
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_kind == KIND_ECHO && out_char >= SPACE_CHAR
			&& out_char != 7'h7F) || (out_kind != KIND_ECHO && out_char == '0)))
		else $error("bad character on output");

endmodule
